>>> design/sfr_pkg.sv
package sfr_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 32;
  localparam int unsigned LEN_W = 6;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] END_BYTE = 8'h03;

  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'd1;

  localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RST = 16'd100;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 6'd32;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] byte_index;
    logic [LEN_W-1:0] frame_length;
    logic             last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic byte_en;
    logic tick_en;
    logic load_len;
    logic store_byte;
    logic add_sum;
    logic clr_idx;
    logic rd_en;
    logic inc_idx;
  } sfr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic len_ok;
    logic data_last;
    logic sum_ok;
    logic timed_out;
    logic out_last;
  } sfr_sts_t;

endpackage

>>> design/sfr_datapath.sv
module sfr_datapath #(
  parameter int unsigned MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [7:0]                       byte_i,
  input  sfr_pkg::sfr_cmd_t                cmd_i,
  output sfr_pkg::sfr_sts_t                sts_o,
  output sfr_pkg::out_item_t               out_data_o
);
  import sfr_pkg::*;

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0] MaxPay8 = 8'(MAX_PAYLOAD);

  logic [TIMEOUT_W-1:0] timeout_q;
  logic [LEN_W-1:0]     max_len_q;
  logic [LEN_W-1:0]     exp_len_q;
  logic [LEN_W-1:0]     wpos_q;
  logic [7:0]           sum_q;
  logic [TIMEOUT_W-1:0] idle_q;
  logic [TIMEOUT_W-1:0] idle_inc;
  logic [LEN_W-1:0]     idx_q;
  logic [7:0]           limit;
  logic [7:0]           mem [MAX_PAYLOAD];
  logic [7:0]           rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= IDLE_TIMEOUT_RST;
      max_len_q <= MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IDLE_TIMEOUT: timeout_q <= cfg_data_i;
        REG_MAX_LENGTH:   max_len_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign idle_inc = (idle_q != '1) ? idle_q + 1'b1 : idle_q;
  assign limit = ({2'b00, max_len_q} < MaxPay8) ? {2'b00, max_len_q} : MaxPay8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q    <= '0;
      exp_len_q <= '0;
      wpos_q    <= '0;
      sum_q     <= '0;
      idx_q     <= '0;
    end else begin
      if (cmd_i.byte_en) begin
        idle_q <= '0;
      end else if (cmd_i.tick_en) begin
        idle_q <= idle_inc;
      end
      if (cmd_i.load_len) begin
        exp_len_q <= byte_i[LEN_W-1:0];
        wpos_q    <= '0;
        sum_q     <= '0;
      end else begin
        if (cmd_i.store_byte) begin
          wpos_q <= wpos_q + 1'b1;
        end
        if (cmd_i.add_sum) begin
          sum_q <= sum_q + byte_i;
        end
      end
      if (cmd_i.clr_idx) begin
        idx_q <= '0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // payload store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte) begin
      mem[wpos_q[AW-1:0]] <= byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_comb begin
    sts_o.len_ok    = (byte_i != 8'd0) && (byte_i <= limit);
    sts_o.data_last = ({1'b0, wpos_q} + 7'd1) >= {1'b0, exp_len_q};
    sts_o.sum_ok    = (sum_q == 8'd0);
    sts_o.timed_out = (idle_inc > timeout_q);
    sts_o.out_last  = ({1'b0, idx_q} + 7'd1) == {1'b0, exp_len_q};
  end

  always_comb begin
    out_data_o.payload_byte = rd_q;
    out_data_o.byte_index   = idx_q[IDX_W-1:0];
    out_data_o.frame_length = exp_len_q;
    out_data_o.last         = sts_o.out_last;
  end

endmodule

>>> design/sfr_ctrl.sv
module sfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_mode_i,
  input  logic [7:0]        in_byte_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sfr_pkg::sfr_sts_t sts_i,
  output sfr_pkg::sfr_cmd_t cmd_o
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_DATA,
    ST_CKSUM,
    ST_END,
    ST_READ,
    ST_SHOW
  } state_e;

  state_e state_q, state_d;
  logic   acc;
  logic   is_byte;
  logic   is_tick;

  assign in_ready_o  = (state_q != ST_READ) && (state_q != ST_SHOW);
  assign out_valid_o = (state_q == ST_SHOW);
  assign acc         = in_valid_i && in_ready_o;
  assign is_byte     = acc && (in_mode_i == MODE_BYTE);
  assign is_tick     = acc && (in_mode_i == MODE_TICK);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.byte_en = is_byte;
    cmd_o.tick_en = is_tick;
    unique case (state_q)
      ST_HUNT: begin
        if (is_byte && in_byte_i == START_BYTE) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        if (is_byte) begin
          if (sts_i.len_ok) begin
            cmd_o.load_len = 1'b1;
            state_d = ST_DATA;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_DATA: begin
        if (is_byte) begin
          cmd_o.store_byte = 1'b1;
          cmd_o.add_sum    = 1'b1;
          if (sts_i.data_last) begin
            state_d = ST_CKSUM;
          end
        end
      end
      ST_CKSUM: begin
        if (is_byte) begin
          cmd_o.add_sum = 1'b1;
          state_d = ST_END;
        end
      end
      ST_END: begin
        if (is_byte) begin
          if (in_byte_i == END_BYTE && sts_i.sum_ok) begin
            cmd_o.clr_idx = 1'b1;
            state_d = ST_READ;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready_i) begin
          if (sts_i.out_last) begin
            state_d = ST_HUNT;
          end else begin
            cmd_o.inc_idx = 1'b1;
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_HUNT;
    endcase
    // a tick past the timeout abandons a partial frame
    if (is_tick && state_q != ST_HUNT && sts_i.timed_out) begin
      state_d = ST_HUNT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/serial_frame_receiver.sv
// Parser: one request (byte or tick) accepted per cycle while a frame is assembled.
// Verified frame: after the end byte is taken, the payload drains through ST_READ (read
// of the single store read port) and ST_SHOW (output) for each byte, the output holding
// while stalled; no requests accepted until the last byte is taken.
// Reset: parser hunts for start byte, counters clear, idle_timeout = 100,
// max_length = 32; the payload store is not cleared.
module serial_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sfr_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sfr_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sfr_pkg::*;

  sfr_cmd_t cmd;
  sfr_sts_t sts;

  sfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_data_i.mode),
    .in_byte_i   (in_data_i.data_byte),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sfr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .byte_i     (in_data_i.data_byte),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

>>> design/sfr_checker.sv
module sfr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sfr_pkg::out_item_t out_data_o
);

  // a waiting result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // no requests taken while a frame drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready during drain");

  // drain continues after a non-final byte, with the next index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> !out_valid_o ##1
      (out_valid_o && out_data_o.byte_index == $past(out_data_o.byte_index, 2) + 5'd1))
    else $error("drain sequence broken");

  // parser resumes after the final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last |=> in_ready_o && !out_valid_o)
    else $error("parser did not resume after frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, out_data_o.byte_index} < out_data_o.frame_length)
    else $error("byte index beyond frame length");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> tb/serial_frame_receiver_check.sv
`timescale 1ns / 1ps

module serial_frame_receiver_check
  import sfr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    frames_o,
  output int                    bytes_o
);

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_DATA,
    ST_CKSUM,
    ST_END
  } parse_state_e;

  parse_state_e            state_q;
  logic [7:0]              frame_buf [MAX_PAYLOAD_DEF];
  logic [LEN_W-1:0]        frame_len;
  int                      wr_pos;
  logic [7:0]              cksum_acc;
  logic [TIMEOUT_W-1:0]    idle_cnt;
  logic [TIMEOUT_W-1:0]    timeout_reg;
  logic [LEN_W-1:0]        max_len_reg;
  out_item_t               verified_bytes_q [$];

  function automatic void report_failure(string what, out_item_t want, out_item_t got);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display({"%0t: %s: expected byte %02h idx %0d len %0d last %0b, ",
                "got byte %02h idx %0d len %0d last %0b"},
               $time, what, want.payload_byte, want.byte_index, want.frame_length, want.last,
               got.payload_byte, got.byte_index, got.frame_length, got.last);
  endfunction

  // Advances the parser by one request and queues the payload of a verified frame.
  function automatic void parse_request(in_item_t req);
    int        len_limit;
    out_item_t res;
    if (req.mode == MODE_TICK) begin
      if (idle_cnt != '1) idle_cnt++;
      if (state_q != ST_HUNT && idle_cnt > timeout_reg) state_q = ST_HUNT;
      return;
    end
    idle_cnt = '0;
    case (state_q)
      ST_LEN: begin
        len_limit = (int'(max_len_reg) < MAX_PAYLOAD_DEF) ? int'(max_len_reg) : MAX_PAYLOAD_DEF;
        if (req.data_byte == 8'd0 || int'(req.data_byte) > len_limit) begin
          state_q = ST_HUNT;
        end else begin
          frame_len = req.data_byte[LEN_W-1:0];
          wr_pos    = 0;
          cksum_acc = 8'd0;
          state_q   = ST_DATA;
        end
      end
      ST_DATA: begin
        if (wr_pos < MAX_PAYLOAD_DEF) frame_buf[wr_pos] = req.data_byte;
        cksum_acc = cksum_acc + req.data_byte;
        wr_pos++;
        if (wr_pos >= int'(frame_len)) state_q = ST_CKSUM;
      end
      ST_CKSUM: begin
        cksum_acc = cksum_acc + req.data_byte;
        state_q   = ST_END;
      end
      ST_END: begin
        if (req.data_byte == END_BYTE && cksum_acc == 8'd0) begin
          for (int i = 0; i < int'(frame_len) && i < MAX_PAYLOAD_DEF; i++) begin
            res.payload_byte = frame_buf[i];
            res.byte_index   = IDX_W'(i);
            res.frame_length = frame_len;
            res.last         = (i + 1 == int'(frame_len));
            verified_bytes_q.push_back(res);
          end
        end
        state_q = ST_HUNT;
      end
      default: begin
        state_q = (req.data_byte == START_BYTE) ? ST_LEN : ST_HUNT;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      state_q      = ST_HUNT;
      frame_len    = '0;
      wr_pos       = 0;
      cksum_acc    = 8'd0;
      idle_cnt     = '0;
      timeout_reg  = IDLE_TIMEOUT_RST;
      max_len_reg  = MAX_LENGTH_RST;
      verified_bytes_q.delete();
      fail_count_o = 0;
      frames_o     = 0;
      bytes_o      = 0;
    end else begin
      // a frame's results come only after its end byte has been taken and registered, so compare first
      if (out_valid_i && out_ready_i) begin
        if (verified_bytes_q.size() == 0) begin
          report_failure("unexpected result", '0, out_data_i);
        end else begin
          want = verified_bytes_q.pop_front();
          if (out_data_i.payload_byte !== want.payload_byte ||
              out_data_i.byte_index   !== want.byte_index   ||
              out_data_i.frame_length !== want.frame_length ||
              out_data_i.last         !== want.last)
            report_failure("mismatch", want, out_data_i);
          bytes_o++;
          if (want.last) frames_o++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IDLE_TIMEOUT: timeout_reg = cfg_data_i[TIMEOUT_W-1:0];
          REG_MAX_LENGTH:   max_len_reg = cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) parse_request(in_data_i);
    end
    pending_o = verified_bytes_q.size();
  end

endmodule

>>> tb/serial_frame_receiver_test.sv
`timescale 1ns / 1ps

module serial_frame_receiver_test;
  import sfr_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = REG_IDLE_TIMEOUT;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int frames_ok;
  int bytes_ok;

  int   reqs_sent = 0;
  int   ticks_sent = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  bit   hold_off = 1'b0;
  int   holds_done = 0;
  int   cur_timeout = IDLE_TIMEOUT_RST;
  int   cur_max_len = MAX_LENGTH_RST;

  always #5 clk_i = ~clk_i;

  serial_frame_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  serial_frame_receiver_check checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .frames_o     (frames_ok),
    .bytes_o      (bytes_ok)
  );

  task automatic push_req(logic mode, logic [7:0] data);
    in_item_t req;
    req.mode      = mode;
    req.data_byte = data;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    reqs_sent++;
    if (mode == MODE_TICK) ticks_sent++;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic push_byte(logic [7:0] data);
    push_req(MODE_BYTE, data);
  endtask

  task automatic push_ticks(int n);
    // byte field is don't-care on ticks; randomize it anyway
    repeat (n) push_req(MODE_TICK, 8'($urandom));
  endtask

  // fill < 0 gives random payload bytes
  task automatic send_frame(int len, bit good_sum, logic [7:0] tail, int fill, int tick_pct);
    logic [7:0] sum;
    logic [7:0] data;
    sum = 8'd0;
    push_byte(START_BYTE);
    push_byte(8'(len));
    for (int i = 0; i < len; i++) begin
      data = (fill < 0) ? 8'($urandom) : 8'(fill);
      sum  = sum + data;
      push_byte(data);
      if ($urandom_range(0, 99) < tick_pct) push_ticks($urandom_range(1, 2));
    end
    if (good_sum) push_byte(8'd0 - sum);
    else push_byte(8'd0 - sum + 8'($urandom_range(1, 255)));
    push_byte(tail);
  endtask

  task automatic drain_and_wait();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    if (idx == REG_IDLE_TIMEOUT) cur_timeout = value;
    else cur_max_len = value;
  endtask

  task automatic random_traffic(int target);
    int pick;
    int len;
    int short_lim;
    while (reqs_sent < target) begin
      pick      = $urandom_range(0, 99);
      short_lim = (cur_max_len < 8) ? cur_max_len : 8;
      if (pick < 65) begin
        len = ($urandom_range(0, 9) == 0) ? cur_max_len : $urandom_range(1, short_lim);
        send_frame(len, $urandom_range(0, 9) != 0,
                   ($urandom_range(0, 9) != 0) ? END_BYTE : 8'($urandom), -1, 8);
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
      end else if (pick < 83) begin
        push_ticks($urandom_range(1, 3));
      end else if (pick < 90) begin
        push_byte(START_BYTE);
        push_byte(($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(cur_max_len + 1, 255)));
      end else begin
        // frame cut short, then left idle
        len = $urandom_range(1, short_lim);
        push_byte(START_BYTE);
        push_byte(8'(len));
        repeat ($urandom_range(0, len + 1)) push_byte(8'($urandom));
        if (cur_timeout <= 8) push_ticks(cur_timeout + 1);
        else push_ticks($urandom_range(1, 3));
      end
    end
  endtask

  initial begin : sink_proc
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
        holds_done++;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n - 1) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("serial_frame_receiver_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset
    gap_pct   = 25;
    stall_pct = 25;
    push_ticks(1);                         // tick while hunting
    send_frame(1, 1'b1, END_BYTE, 8'h00, 0);
    send_frame(2, 1'b1, END_BYTE, 8'hFF, 0);
    push_byte(START_BYTE);
    push_byte(8'd0);                       // zero length
    push_byte(START_BYTE);
    push_byte(8'd33);                      // one above the limit
    push_byte(START_BYTE);
    push_byte(8'hFF);
    send_frame(1, 1'b0, END_BYTE, -1, 0);  // bad checksum
    send_frame(1, 1'b1, 8'hFF, -1, 0);     // bad end byte
    send_frame(3, 1'b1, END_BYTE, -1, 100);// idle ticks below timeout
    random_traffic(60);

    drain_and_wait();
    write_reg(REG_IDLE_TIMEOUT, 1);
    write_reg(REG_MAX_LENGTH, 1);
    gap_pct   = 40;
    stall_pct = 10;
    push_byte(START_BYTE);
    push_byte(8'd1);
    push_ticks(2);                         // abandons the frame
    send_frame(1, 1'b1, END_BYTE, -1, 0);
    random_traffic(110);

    drain_and_wait();
    write_reg(REG_IDLE_TIMEOUT, 65535);
    write_reg(REG_MAX_LENGTH, 32);
    gap_pct   = 20;
    stall_pct = 30;
    hold_off  = 1'b1;                      // output held off while input keeps coming
    send_frame(32, 1'b1, END_BYTE, -1, 0);
    send_frame(4, 1'b1, END_BYTE, -1, 0);
    random_traffic(180);

    drain_and_wait();
    write_reg(REG_IDLE_TIMEOUT, 5);
    write_reg(REG_MAX_LENGTH, 17);
    gap_pct   = 30;
    stall_pct = 30;
    random_traffic(215);
    gap_pct   = 0;
    stall_pct = 0;
    random_traffic(250);

    drain_and_wait();
    repeat (20) @(posedge clk_i);
    $display("covered %0d requests (%0d ticks), %0d verified frames, %0d payload bytes",
             reqs_sent, ticks_sent, frames_ok, bytes_ok);
    $display("timeout 100/1/65535/5, max length 32/1/32/17, %0d long output hold-off(s)",
             holds_done);
    if (fail_count == 0 && pending == 0) begin
      $display("serial_frame_receiver_test OK");
    end else begin
      $display("%0d failures, %0d results still expected", fail_count, pending);
      $display("serial_frame_receiver_test NOT OK");
    end
    $finish;
  end

endmodule
